### rtl/sepq_pkg.sv
// shared constants and types for the sorted event priority queue
package sepq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 32;
  localparam int KIND_BITS   = 4;
  localparam int TAG_BITS    = 16;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_DATA_W  = 56;  // time, kind, tag padded to bytes
  localparam int OUT_DATA_W = 64;  // time, kind, tag, count padded to bytes
  localparam int OUT_USER_W = 2;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_QUERY = 2'd2
  } action_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [TIME_BITS-1:0] time_val;
    logic [KIND_BITS-1:0] kind;
    logic [TAG_BITS-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic load;  // capture the incoming transfer
    logic exec;  // apply the item to the queue and load the result
  } cmd_t;

  typedef struct packed {
    logic out_stall;  // result register still holds an untaken result
  } sts_t;

endpackage

### rtl/sorted_event_priority_queue.sv
// top level of the sorted event priority queue
//
// one input stream carries commands: tuser selects push, pop or query and tdata
// holds the event time, kind and tag of a push. every accepted command yields
// exactly one result transfer with the head entry, the entry count, an empty
// flag and a refused flag (push on a full queue or pop on an empty one).
// entries are held in a row of slot registers kept in time order; a push
// compares the new time against every slot at once and shifts the later ones
// back, a pop shifts all slots forward by one.
// an item is captured into the input register at its transfer edge; a later edge
// applies it to the slots and loads the result register once that register is
// free, and no new command is taken until the captured item has been applied.
// the command after that is still taken while a result waits; it is held in
// place and not applied until the receiver takes the older result.
// reset empties the queue and drops any pending result; slot contents are not
// cleared since only slots below the fill count are ever read.
module sorted_event_priority_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [55:0]: event_time [31:0], event_kind [35:32], event_tag [51:36], zero pad
  input  logic [sepq_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // [1:0]: action
  input  logic [1:0]                          s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [63:0]: head_time [31:0], head_kind [35:32], head_tag [51:36],
  //         entry_count [56:52], zero pad
  output logic [sepq_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // [1:0]: queue_empty [0], refused [1]
  output logic [sepq_pkg::OUT_USER_W-1:0]     m_axis_tuser_o
);

  sepq_pkg::cmd_t cmd;
  sepq_pkg::sts_t sts;

  sepq_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  sepq_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

### rtl/sepq_ctrl.sv
// controller state machine for the sorted event priority queue
module sepq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  sepq_pkg::sts_t  sts_i,
  output sepq_pkg::cmd_t  cmd_o
);

  sepq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sepq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sepq_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = sepq_pkg::ST_EXEC;
        end
      end
      sepq_pkg::ST_EXEC: begin
        if (!sts_i.out_stall) begin
          state_d = sepq_pkg::ST_IDLE;
        end
      end
      default: state_d = sepq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    cmd_o           = '0;
    case (state_q)
      sepq_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        cmd_o.load      = s_axis_tvalid_i;
      end
      sepq_pkg::ST_EXEC: begin
        cmd_o.exec = !sts_i.out_stall;
      end
      default: begin
        s_axis_tready_o = 1'b0;
      end
    endcase
  end

  a_exec_only_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> $past(cmd_o.load) || $past(state_q == sepq_pkg::ST_EXEC))
    else $error("exec without a captured item");

  a_no_exec_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.out_stall |-> !cmd_o.exec)
    else $error("exec issued while result register is occupied");

  a_load_returns_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == sepq_pkg::ST_EXEC)
    else $error("captured item not executed");

endmodule

### rtl/sepq_datapath.sv
// slot array, insertion compare and result register of the event queue
module sepq_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sepq_pkg::cmd_t                      cmd_i,
  output sepq_pkg::sts_t                      sts_o,
  input  logic [1:0]                          s_axis_tuser_i,
  input  logic [sepq_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [sepq_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  output logic [sepq_pkg::OUT_USER_W-1:0]     m_axis_tuser_o
);

  localparam int EntryW = $bits(sepq_pkg::entry_t);
  localparam int PadW   = sepq_pkg::OUT_DATA_W - sepq_pkg::TIME_BITS - sepq_pkg::KIND_BITS
                          - sepq_pkg::TAG_BITS - sepq_pkg::COUNT_W;

  logic [1:0]                       act_q;
  sepq_pkg::entry_t                 new_q;
  sepq_pkg::entry_t                 slots_q [sepq_pkg::QUEUE_DEPTH];
  sepq_pkg::entry_t                 slots_d [sepq_pkg::QUEUE_DEPTH];
  logic [sepq_pkg::COUNT_W-1:0]     fill_q, fill_d;
  logic [sepq_pkg::QUEUE_DEPTH-1:0] stay;
  logic                             full, empty, do_push, do_pop, refused;
  logic                             out_valid_q, out_valid_d;
  sepq_pkg::entry_t                 out_head_q;
  logic [sepq_pkg::COUNT_W-1:0]     out_count_q;
  logic                             out_empty_q, out_refused_q;

  // capture the incoming item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q          <= s_axis_tuser_i;
      new_q.time_val <= s_axis_tdata_i[sepq_pkg::TIME_BITS-1:0];
      new_q.kind     <= s_axis_tdata_i[sepq_pkg::TIME_BITS +: sepq_pkg::KIND_BITS];
      new_q.tag      <= s_axis_tdata_i[sepq_pkg::TIME_BITS + sepq_pkg::KIND_BITS +:
                                       sepq_pkg::TAG_BITS];
    end
  end

  assign full    = fill_q == sepq_pkg::COUNT_W'(sepq_pkg::QUEUE_DEPTH);
  assign empty   = fill_q == '0;
  assign do_push = (act_q == sepq_pkg::ACT_PUSH) && !full;
  assign do_pop  = (act_q == sepq_pkg::ACT_POP) && !empty;
  assign refused = ((act_q == sepq_pkg::ACT_PUSH) && full) ||
                   ((act_q == sepq_pkg::ACT_POP) && empty);

  // per-slot compare: a held entry stays in place when it sorts ahead of the new one;
  // an equal time keeps the head ahead but lets the new entry pass the others
  always_comb begin
    for (int i = 0; i < sepq_pkg::QUEUE_DEPTH; i++) begin
      if (i == 0) begin
        stay[i] = (sepq_pkg::COUNT_W'(i) < fill_q) &&
                  (slots_q[i].time_val <= new_q.time_val);
      end else begin
        stay[i] = (sepq_pkg::COUNT_W'(i) < fill_q) &&
                  (slots_q[i].time_val < new_q.time_val);
      end
    end
  end

  always_comb begin
    slots_d[0] = slots_q[0];
    if (do_push && !stay[0]) begin
      slots_d[0] = new_q;
    end else if (do_pop) begin
      slots_d[0] = slots_q[1];
    end
    for (int i = 1; i < sepq_pkg::QUEUE_DEPTH; i++) begin
      slots_d[i] = slots_q[i];
      if (do_push && !stay[i]) begin
        slots_d[i] = stay[i-1] ? new_q : slots_q[i-1];
      end else if (do_pop && (i < sepq_pkg::QUEUE_DEPTH - 1)) begin
        slots_d[i] = slots_q[(i + 1) % sepq_pkg::QUEUE_DEPTH];
      end
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (do_push) begin
      fill_d = fill_q + sepq_pkg::COUNT_W'(1);
    end else if (do_pop) begin
      fill_d = fill_q - sepq_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      for (int i = 0; i < sepq_pkg::QUEUE_DEPTH; i++) begin
        slots_q[i] <= slots_d[i];
      end
      out_head_q    <= (fill_d == '0) ? EntryW'(0) : slots_d[0];
      out_count_q   <= fill_d;
      out_empty_q   <= fill_d == '0;
      out_refused_q <= refused;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.exec) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.exec) begin
        fill_q <= fill_d;
      end
    end
  end

  assign sts_o.out_stall = out_valid_q && !m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {PadW'(0), out_count_q, out_head_q.tag, out_head_q.kind,
                            out_head_q.time_val};
  assign m_axis_tuser_o  = {out_refused_q, out_empty_q};

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= sepq_pkg::COUNT_W'(sepq_pkg::QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> (fill_q == $past(fill_q)) ||
                   (fill_q == $past(fill_q) + sepq_pkg::COUNT_W'(1)) ||
                   (fill_q == $past(fill_q) - sepq_pkg::COUNT_W'(1)))
    else $error("fill count moved by more than one");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q >= sepq_pkg::COUNT_W'(2)) |-> slots_q[0].time_val <= slots_q[1].time_val)
    else $error("head entry out of order");

  a_empty_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_empty_q == (out_count_q == '0)))
    else $error("empty flag disagrees with entry count");

endmodule

### tb/sorted_event_priority_queue_tb.sv
// self-checking testbench for the sorted event priority queue
`timescale 1ns / 100ps

module sorted_event_priority_queue_tb;

  localparam logic [1:0] ACT_SPARE = 2'd3;  // unused code, acts as a query
  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 12;
  localparam int MAX_WAIT     = 10;
  localparam int RANDOM_CMDS  = 830;
  localparam int IDLE_LIMIT   = 2000;
  localparam int REPORT_LIMIT = 10;
  localparam int DRAIN_CYCLES = 6;
  localparam int PAD_W        = sepq_pkg::IN_DATA_W - sepq_pkg::TIME_BITS
                                - sepq_pkg::KIND_BITS - sepq_pkg::TAG_BITS;

  typedef struct packed {
    logic                           empty;
    logic [sepq_pkg::TIME_BITS-1:0] head_time;
    logic [sepq_pkg::KIND_BITS-1:0] head_kind;
    logic [sepq_pkg::TAG_BITS-1:0]  head_tag;
    logic                           refused;
    logic [sepq_pkg::COUNT_W-1:0]   count;
  } head_report_t;

  typedef struct packed {
    logic [1:0]                     act;
    logic [sepq_pkg::TIME_BITS-1:0] t;
    logic [sepq_pkg::KIND_BITS-1:0] k;
    logic [sepq_pkg::TAG_BITS-1:0]  g;
    logic                           typed;  // want holds a hand-written expectation
    head_report_t                   want;
  } script_row_t;

  localparam head_report_t NO_WANT = '0;
  localparam head_report_t WANT_EMPTY = '{1'b1, '0, '0, '0, 1'b0, '0};
  localparam head_report_t WANT_EMPTY_REFUSED = '{1'b1, '0, '0, '0, 1'b1, '0};

  localparam int SCRIPT_LEN = 24;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{sepq_pkg::ACT_POP,   32'h0000_0000, 4'h0, 16'h0000, 1'b1, WANT_EMPTY_REFUSED},
    '{sepq_pkg::ACT_QUERY, 32'hFFFF_FFFF, 4'hF, 16'hFFFF, 1'b1, WANT_EMPTY},
    '{ACT_SPARE,           32'h0000_0000, 4'h0, 16'h0000, 1'b1, WANT_EMPTY},
    '{sepq_pkg::ACT_PUSH,  32'hFFFF_FFFF, 4'hF, 16'hFFFF, 1'b1,
      '{1'b0, 32'hFFFF_FFFF, 4'hF, 16'hFFFF, 1'b0, 5'd1}},
    '{sepq_pkg::ACT_PUSH,  32'h0000_0000, 4'h0, 16'h0000, 1'b1,
      '{1'b0, 32'h0000_0000, 4'h0, 16'h0000, 1'b0, 5'd2}},
    // equal to the head: must land behind it
    '{sepq_pkg::ACT_PUSH,  32'h0000_0000, 4'h5, 16'h1234, 1'b0, NO_WANT},
    '{sepq_pkg::ACT_PUSH,  32'h0000_0064, 4'hA, 16'h00AA, 1'b0, NO_WANT},
    '{sepq_pkg::ACT_PUSH,  32'h0000_0032, 4'h3, 16'h0033, 1'b0, NO_WANT},
    // equal to a non-head entry: goes ahead of it
    '{sepq_pkg::ACT_PUSH,  32'h0000_0064, 4'hC, 16'h0C0C, 1'b0, NO_WANT},
    '{sepq_pkg::ACT_PUSH,  32'h7FFF_FFFF, 4'h6, 16'h5555, 1'b0, NO_WANT},
    '{sepq_pkg::ACT_PUSH,  32'h8000_0000, 4'h9, 16'hAAAA, 1'b0, NO_WANT},
    '{sepq_pkg::ACT_PUSH,  32'hFFFF_FFFF, 4'h1, 16'h0001, 1'b0, NO_WANT},
    '{sepq_pkg::ACT_PUSH,  32'hFFFF_FFFE, 4'h2, 16'h8000, 1'b0, NO_WANT},
    '{sepq_pkg::ACT_PUSH,  32'h0000_0001, 4'h4, 16'h0F0F, 1'b0, NO_WANT},
    '{sepq_pkg::ACT_PUSH,  32'h0000_0002, 4'h8, 16'hF0F0, 1'b0, NO_WANT},
    '{sepq_pkg::ACT_PUSH,  32'h0000_0064, 4'h7, 16'h7777, 1'b0, NO_WANT},
    '{sepq_pkg::ACT_PUSH,  32'h0000_0003, 4'hE, 16'hFFFE, 1'b0, NO_WANT},
    '{sepq_pkg::ACT_PUSH,  32'h1234_5678, 4'hD, 16'h1357, 1'b0, NO_WANT},
    '{sepq_pkg::ACT_PUSH,  32'h0000_0000, 4'hB, 16'h2468, 1'b0, NO_WANT},
    // queue is full now
    '{sepq_pkg::ACT_PUSH,  32'h0000_0005, 4'hF, 16'hFFFF, 1'b1,
      '{1'b0, 32'h0000_0000, 4'h0, 16'h0000, 1'b1, 5'd16}},
    '{sepq_pkg::ACT_QUERY, 32'h0000_0000, 4'h0, 16'h0000, 1'b1,
      '{1'b0, 32'h0000_0000, 4'h0, 16'h0000, 1'b0, 5'd16}},
    '{sepq_pkg::ACT_POP,   32'hA5A5_A5A5, 4'hA, 16'h5A5A, 1'b0, NO_WANT},
    '{ACT_SPARE,           32'hFFFF_FFFF, 4'hF, 16'hFFFF, 1'b0, NO_WANT},
    '{sepq_pkg::ACT_POP,   32'h0000_0000, 4'h0, 16'h0000, 1'b0, NO_WANT}
  };

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid_i;
  logic                            s_axis_tready_o;
  logic [sepq_pkg::IN_DATA_W-1:0]  s_axis_tdata_i;
  logic [1:0]                      s_axis_tuser_i;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i;
  logic [sepq_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [sepq_pkg::OUT_USER_W-1:0] m_axis_tuser_o;

  sorted_event_priority_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // shadow copy of the sorted slots
  sepq_pkg::entry_t slots [sepq_pkg::QUEUE_DEPTH];
  int               held;
  head_report_t     head_reports_due [$];

  int unsigned  n_push, n_pop, n_query, n_refused, n_full, n_empty;
  int unsigned  n_results, err_count;
  bit           send_steady;

  function automatic head_report_t predict_head(input logic [1:0] act,
                                                input sepq_pkg::entry_t ev);
    head_report_t rep;
    int pos;
    rep = '0;
    if (act == sepq_pkg::ACT_PUSH) begin
      n_push++;
      if (held == sepq_pkg::QUEUE_DEPTH) begin
        rep.refused = 1'b1;
      end else begin
        pos = 0;
        // never overtake an equal-time head, but overtake equal times behind it
        if (held != 0 && slots[0].time_val <= ev.time_val) begin
          pos = 1;
          while (pos < held && slots[pos].time_val < ev.time_val) pos++;
        end
        for (int i = held; i > pos; i--) slots[i] = slots[i-1];
        slots[pos] = ev;
        held++;
        if (held == sepq_pkg::QUEUE_DEPTH) n_full++;
      end
    end else if (act == sepq_pkg::ACT_POP) begin
      n_pop++;
      if (held == 0) begin
        rep.refused = 1'b1;
      end else begin
        for (int i = 1; i < held; i++) slots[i-1] = slots[i];
        held--;
        if (held == 0) n_empty++;
      end
    end else begin
      n_query++;
    end
    if (rep.refused) n_refused++;
    rep.empty = (held == 0);
    if (held != 0) begin
      rep.head_time = slots[0].time_val;
      rep.head_kind = slots[0].kind;
      rep.head_tag  = slots[0].tag;
    end
    rep.count = sepq_pkg::COUNT_W'(held);
    return rep;
  endfunction

  task automatic check_head(input head_report_t want, input head_report_t got);
    logic bad;
    bad = (got.empty !== want.empty) || (got.head_time !== want.head_time) ||
          (got.head_kind !== want.head_kind) || (got.head_tag !== want.head_tag) ||
          (got.refused !== want.refused) || (got.count !== want.count);
    if (bad) begin
      err_count++;
      if (err_count <= REPORT_LIMIT) begin
        $display("mismatch at %0t result %0d", $time, n_results);
        $display("  want empty=%b time=%h kind=%h tag=%h ref=%b cnt=%0d",
                 want.empty, want.head_time, want.head_kind, want.head_tag,
                 want.refused, want.count);
        $display("  got  empty=%b time=%h kind=%h tag=%h ref=%b cnt=%0d",
                 got.empty, got.head_time, got.head_kind, got.head_tag,
                 got.refused, got.count);
      end
    end
  endtask

  task automatic send_cmd(input logic [1:0] act,
                          input logic [sepq_pkg::TIME_BITS-1:0] t,
                          input logic [sepq_pkg::KIND_BITS-1:0] k,
                          input logic [sepq_pkg::TAG_BITS-1:0] g,
                          input logic typed, input head_report_t want);
    int gap;
    sepq_pkg::entry_t ev;
    head_report_t pred;
    gap = send_steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{PAD_W{1'b0}}, g, k, t};
    s_axis_tuser_i  <= act;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    ev.time_val = t;
    ev.kind     = k;
    ev.tag      = g;
    pred = predict_head(act, ev);
    head_reports_due.push_back(typed ? want : pred);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // result side: random stalls, compare each transfer with the oldest prediction
  initial begin
    int stall;
    bit steady;
    head_report_t got;
    m_axis_tready_i = 1'b0;
    steady = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (n_results % 100 == 0) steady = ($urandom_range(0, 2) == 0);
      stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        @(negedge clk_i);
        m_axis_tready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      got.empty     = m_axis_tuser_o[0];
      got.refused   = m_axis_tuser_o[1];
      got.head_time = m_axis_tdata_o[31:0];
      got.head_kind = m_axis_tdata_o[35:32];
      got.head_tag  = m_axis_tdata_o[51:36];
      got.count     = m_axis_tdata_o[56:52];
      if (head_reports_due.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_LIMIT)
          $display("unexpected result at %0t: time=%h cnt=%0d",
                   $time, got.head_time, got.count);
      end else begin
        check_head(head_reports_due.pop_front(), got);
      end
      n_results++;
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int idle;
    idle = 0;
    @(posedge rst_ni);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle = 0;
      else
        idle++;
    end
    $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
    $display("sorted_event_priority_queue_tb: errors");
    $finish;
  end

  initial begin
    int push_pct, r;
    logic [1:0] act;
    logic [sepq_pkg::TIME_BITS-1:0] t, last_time;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = sepq_pkg::ACT_QUERY;
    held            = 0;
    send_steady     = 1'b0;
    last_time       = '0;
    push_pct        = 50;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (SCRIPT[i])
      send_cmd(SCRIPT[i].act, SCRIPT[i].t, SCRIPT[i].k, SCRIPT[i].g, SCRIPT[i].typed,
               SCRIPT[i].want);

    for (int n = 0; n < RANDOM_CMDS; n++) begin
      // fill level drifts with the push share so both full and empty get visited
      if (n % 32 == 0) push_pct = $urandom_range(15, 85);
      if (n % 100 == 0) send_steady = ($urandom_range(0, 2) == 0);
      if (n == RANDOM_CMDS / 2) begin
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
        while (head_reports_due.size() != 0) @(posedge clk_i);
      end
      r = $urandom_range(0, 99);
      if (r < push_pct) act = sepq_pkg::ACT_PUSH;
      else if ($urandom_range(0, 9) < 8) act = sepq_pkg::ACT_POP;
      else act = $urandom_range(0, 1) ? sepq_pkg::ACT_QUERY : ACT_SPARE;
      case ($urandom_range(0, 4))
        0: t = $urandom_range(0, 15);
        1: t = $urandom;
        2: t = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3) : $urandom_range(0, 3);
        3: t = $urandom_range(0, 1000);
        default: t = last_time;  // repeat a time to build ties
      endcase
      if (act == sepq_pkg::ACT_PUSH) last_time = t;
      send_cmd(act, t, 4'($urandom), 16'($urandom), 1'b0, NO_WANT);
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (head_reports_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d commands: %0d pushes, %0d pops, %0d queries, %0d refused",
             n_push + n_pop + n_query, n_push, n_pop, n_query, n_refused);
    $display("queue reached full %0d times and drained to empty %0d times, %0d mismatches",
             n_full, n_empty, err_count);
    if (err_count == 0)
      $display("sorted_event_priority_queue_tb: clean");
    else
      $display("sorted_event_priority_queue_tb: errors");
    $finish;
  end

endmodule
